### rtl/core/mga_pkg.sv
// Shared types, constants and arithmetic helpers for the gradient accumulator.
package mga_pkg;

  localparam int INPUT_COUNT  = 11;
  localparam int HIDDEN_COUNT = 16;
  localparam int SIG_DEPTH    = 256;

  localparam int W1_COUNT = INPUT_COUNT * HIDDEN_COUNT;
  localparam int KW       = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
  localparam int JW       = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
  localparam int ADDR_W   = (W1_COUNT > 1) ? $clog2(W1_COUNT) : 1;
  localparam int SIG_IW   = $clog2(SIG_DEPTH);
  localparam int ACC_W    = 52;
  localparam int NUM_W    = 54;

  // read map beyond the gradient stores
  localparam int RD_SE    = W1_COUNT + HIDDEN_COUNT;
  localparam int RD_PSUM  = RD_SE + 1;
  localparam int RD_PMAX  = RD_SE + 2;
  localparam int RD_ROWS  = RD_SE + 3;

  localparam logic [16:0] Q_ONE = 17'h10000;

  typedef enum logic [2:0] {
    OP_LOAD_W1 = 3'd0,
    OP_LOAD_W2 = 3'd1,
    OP_FEATURE = 3'd2,
    OP_TARGET  = 3'd3,
    OP_READ    = 3'd4,
    OP_CLEAR   = 3'd5
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ,
    ST_FWD_RD, ST_FWD_MUL, ST_FWD_ACC, ST_FWD_SIG,
    ST_OUT_MUL, ST_OUT_ACC, ST_PRED,
    ST_D1, ST_D2, ST_D3, ST_D4, ST_DIV, ST_PCT,
    ST_B1, ST_B2, ST_B3, ST_B4, ST_B5, ST_B6,
    ST_G_RD, ST_G_WR, ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [31:0] w2;
    logic        [16:0] h;
    logic signed [47:0] g2;
  } cell_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic load;
  } cell_ctl_t;

  typedef logic [16:0] sig_word_t;
  typedef sig_word_t sig_tab_t [SIG_DEPTH];

  // shift-and-subtract quotient for the elaboration-time table arithmetic
  function automatic logic [63:0] const_udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sigmoid(-8 + 16*i/depth) in unsigned Q1.16, series exp evaluated at elaboration
  function automatic sig_tab_t build_sig_table();
    sig_tab_t    tab;
    longint      num;
    logic [63:0] a, tq, x, g, term, r, den, s;
    for (int i = 0; i < SIG_DEPTH; i++) begin
      num  = 16 * i - 8 * SIG_DEPTH;
      a    = (num < 0) ? 64'(-num) : 64'(num);
      tq   = const_udiv(a << 32, 64'(SIG_DEPTH));
      x    = tq >> 4;
      g    = 64'd1 << 32;
      term = 64'd1 << 32;
      for (int k = 1; k <= 20; k++) begin
        term = const_udiv((term * x) >> 32, 64'(k));
        g    = g + term;
      end
      r = const_udiv(64'd1 << 63, g) << 1;
      if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      for (int k = 0; k < 4; k++) r = (r * r) >> 32;
      den    = (64'd1 << 32) + r;
      s      = const_udiv((64'd1 << 48) + (den >> 1), den);
      tab[i] = (num < 0) ? 17'(64'd65536 - s) : 17'(s);
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

  function automatic logic [16:0] sig_lookup(input logic signed [ACC_W-1:0] x);
    logic [19:0]       off;
    logic [32:0]       sc;
    logic [SIG_IW-1:0] idx;
    off = 20'(x + 52'sd524288);
    sc  = 33'(off) * 33'(SIG_DEPTH);
    idx = SIG_IW'(sc >> 20);
    if (x < -52'sd524288) idx = '0;
    else if (x >= 52'sd524288) idx = SIG_IW'(SIG_DEPTH - 1);
    return SIG_TABLE[idx];
  endfunction

  // saturating add into a 48-bit accumulator
  function automatic logic signed [47:0] sat_acc(input logic signed [47:0] a,
                                                 input logic signed [49:0] d);
    logic signed [50:0] s;
    s = 51'(a) + 51'(d);
    if (s > 51'sd140737488355327) return 48'sh7FFF_FFFF_FFFF;
    if (s < -51'sd140737488355328) return 48'sh8000_0000_0000;
    return 48'(s);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return 32'(v);
  endfunction

endpackage

### rtl/core/mga_in_if.sv
// Request channel carrying opcode, index and value.
interface mga_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  opcode;
  logic        [7:0]  index;
  logic signed [31:0] value;

  modport source (output valid, opcode, index, value, input ready);
  modport sink   (input valid, opcode, index, value, output ready);
endinterface

### rtl/core/mga_out_if.sv
// Result channel carrying prediction or read data.
interface mga_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] read_value;
  logic               result_kind;

  modport source (output valid, read_value, result_kind, input ready);
  modport sink   (input valid, read_value, result_kind, output ready);
endinterface

### rtl/core/mga_cell.sv
// One hidden-node cell of the rotating chain: output weight, activation, gradient.
module mga_cell (
  input  logic               clk,
  input  logic               rst,
  input  mga_pkg::cell_ctl_t ctl,
  input  mga_pkg::cell_t     shin,
  input  logic signed [31:0] w2_value,
  output mga_pkg::cell_t     q
);
  import mga_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      q.w2 <= shin.w2;
      q.h  <= shin.h;
    end else if (ctl.load) begin
      q.w2 <= w2_value;
    end
    if (rst || ctl.clear) begin
      q.g2 <= '0;
    end else if (ctl.shift) begin
      q.g2 <= shin.g2;
    end
  end

endmodule

### rtl/core/mga_divider.sv
// Restoring divider, one quotient bit per cycle, for the percentage error.
module mga_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mga_pkg::NUM_W-1:0] numer,
  input  logic [31:0]               denom,
  output logic                      busy,
  output logic [mga_pkg::NUM_W-1:0] quot
);
  import mga_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0] cnt;
  logic [31:0]   rem;
  logic [31:0]   den;
  logic [32:0]   trial;
  logic          fits;

  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      den  <= denom;
      quot <= numer;
    end else if (busy) begin
      rem  <= fits ? 32'(trial - {1'b0, den}) : trial[31:0];
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");

endmodule

### rtl/core/mlp_gradient_accumulator_unit.sv
// Top level: request decode, row sequencer, shared multiplier, weight and gradient stores.
// Loads, features and clear are taken in the idle state; a read result is registered once
// the result register is free. Before a target request puts its prediction out, the single
// shared multiplier walks 176 input weights, 16 hidden nodes and 192 gradients, and the
// bit-serial percentage divider runs unless the target is zero. One request is worked at
// a time; a result held by the sink stalls. Synchronous reset clears gradients and metrics.
module mlp_gradient_accumulator_unit (
  input  logic         clk,
  input  logic         rst,
  mga_in_if.sink       feed,
  mga_out_if.source    result
);
  import mga_pkg::*;

  state_t state, state_next;

  logic accept, out_free, shift, k_last, j_last, div_start, div_busy;
  op_t  opc;

  logic [KW-1:0]     kcnt;
  logic [JW-1:0]     jcnt;
  logic [ADDR_W-1:0] w_addr, g1_raddr;

  logic signed [31:0] w1_mem [W1_COUNT];
  logic signed [31:0] w1_rdata;
  logic signed [47:0] g1_mem [W1_COUNT];
  logic signed [47:0] g1_rdata;
  logic [W1_COUNT-1:0] g1_valid;
  logic               g1_rvalid;
  logic               g1_we;
  logic signed [47:0] g1_wdata;

  logic signed [31:0] xf [INPUT_COUNT];

  cell_t     cell_q [HIDDEN_COUNT];
  cell_t     head, tail_in;
  cell_ctl_t cell_ctl [HIDDEN_COUNT];

  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] prod, prod_q16;

  logic signed [31:0]      y;
  logic signed [ACC_W-1:0] acc;
  logic        [16:0]      p, sig_w;
  logic signed [33:0]      err, delta;
  logic signed [47:0]      tt, g2n;
  logic        [15:0]      hp;
  logic        [38:0]      lowp;
  logic signed [31:0]      hd;
  logic signed [63:0]      full;
  logic [7:0]              rd_idx, rd_off;

  logic signed [47:0] se_sum, pct_sum;
  logic        [31:0] pct_max, rows_done;

  logic [33:0]      ae;
  logic [39:0]      ae100;
  logic [31:0]      ay;
  logic [NUM_W-1:0] quot;
  logic [30:0]      pct;

  assign opc      = op_t'(feed.opcode);
  assign feed.ready = (state == ST_IDLE);
  assign accept   = feed.valid && feed.ready;
  assign out_free = !result.valid || result.ready;
  assign k_last   = (kcnt == KW'(INPUT_COUNT - 1));
  assign j_last   = (jcnt == JW'(HIDDEN_COUNT - 1));
  assign w_addr   = ADDR_W'(kcnt * HIDDEN_COUNT) + ADDR_W'(jcnt);
  // hold the read address while a read waits for the result register
  assign g1_raddr = (state == ST_IDLE) ? ADDR_W'(feed.index) :
                    (state == ST_READ) ? ADDR_W'(rd_idx) : w_addr;
  assign prod_q16 = prod >>> 16;
  assign sig_w    = sig_lookup(acc);
  assign head     = cell_q[0];
  assign full     = (64'($signed(prod[39:0])) <<< 24) + 64'(lowp);
  assign rd_off   = rd_idx - 8'(W1_COUNT);

  // percentage divider operands
  assign ae        = err[33] ? 34'(-err) : 34'(err);
  assign ae100     = 40'(ae) * 40'd100;
  assign ay        = y[31] ? 32'(-y) : 32'(y);
  assign div_start = (state == ST_D4) && (y != 32'sd0);
  assign pct       = (y == 32'sd0) ? 31'd0 :
                     (|quot[NUM_W-1:31]) ? 31'h7FFF_FFFF : quot[30:0];

  mga_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer ({ae100[37:0], 16'b0}),
    .denom (ay),
    .busy  (div_busy),
    .quot  (quot)
  );

  // hidden-node chain: head is cell 0, the updated head re-enters at the tail
  always_comb begin
    tail_in = head;
    if (state == ST_FWD_SIG) tail_in.h  = sig_w;
    if (state == ST_G_WR)    tail_in.g2 = g2n;
  end

  for (genvar i = 0; i < HIDDEN_COUNT; i++) begin : g_chain
    assign cell_ctl[i].shift = shift;
    assign cell_ctl[i].clear = accept && (opc == OP_CLEAR);
    assign cell_ctl[i].load  = accept && (opc == OP_LOAD_W2) && (feed.index == 8'(i));
    mga_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (cell_ctl[i]),
      .shin     ((i == HIDDEN_COUNT - 1) ? tail_in : cell_q[(i + 1) % HIDDEN_COUNT]),
      .w2_value (feed.value),
      .q        (cell_q[i])
    );
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_FWD_MUL: begin mul_a = 35'(xf[kcnt]);              mul_b = 35'(w1_rdata); end
      ST_OUT_MUL: begin mul_a = $signed({18'b0, head.h});   mul_b = 35'(head.w2); end
      ST_D1:      begin mul_a = 35'(err);                   mul_b = $signed({18'b0, p}); end
      ST_D2: begin
        mul_a = $signed(prod_q16[34:0]);
        mul_b = $signed({18'b0, 17'(Q_ONE - p)});
      end
      ST_D3:      begin mul_a = 35'(err);                   mul_b = 35'(err); end
      ST_B1:      begin mul_a = $signed({18'b0, head.h});   mul_b = 35'(delta); end
      ST_B2:      begin mul_a = 35'(delta);                 mul_b = 35'(head.w2); end
      ST_B3: begin
        mul_a = $signed({18'b0, head.h});
        mul_b = $signed({18'b0, 17'(Q_ONE - head.h)});
      end
      ST_B4:      begin mul_a = $signed({11'b0, tt[23:0]}); mul_b = $signed({19'b0, prod_q16[15:0]}); end
      ST_B5:      begin mul_a = 35'($signed(tt[47:24]));    mul_b = $signed({19'b0, hp}); end
      ST_G_RD:    begin mul_a = 35'(xf[kcnt]);              mul_b = 35'(hd); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    shift      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && opc == OP_TARGET)    state_next = ST_FWD_RD;
        else if (accept && opc == OP_READ) state_next = ST_READ;
      end
      ST_READ:    if (out_free) state_next = ST_IDLE;
      ST_FWD_RD:  state_next = ST_FWD_MUL;
      ST_FWD_MUL: state_next = ST_FWD_ACC;
      ST_FWD_ACC: state_next = k_last ? ST_FWD_SIG : ST_FWD_RD;
      ST_FWD_SIG: begin
        shift      = 1'b1;
        state_next = j_last ? ST_OUT_MUL : ST_FWD_RD;
      end
      ST_OUT_MUL: state_next = ST_OUT_ACC;
      ST_OUT_ACC: begin
        shift      = 1'b1;
        state_next = j_last ? ST_PRED : ST_OUT_MUL;
      end
      ST_PRED:    state_next = ST_D1;
      ST_D1:      state_next = ST_D2;
      ST_D2:      state_next = ST_D3;
      ST_D3:      state_next = ST_D4;
      ST_D4:      state_next = (y == 32'sd0) ? ST_PCT : ST_DIV;
      ST_DIV:     if (!div_busy) state_next = ST_PCT;
      ST_PCT:     state_next = ST_B1;
      ST_B1:      state_next = ST_B2;
      ST_B2:      state_next = ST_B3;
      ST_B3:      state_next = ST_B4;
      ST_B4:      state_next = ST_B5;
      ST_B5:      state_next = ST_B6;
      ST_B6:      state_next = ST_G_RD;
      ST_G_RD:    state_next = ST_G_WR;
      ST_G_WR: begin
        if (k_last) begin
          shift      = 1'b1;
          state_next = j_last ? ST_DONE : ST_B1;
        end else begin
          state_next = ST_G_RD;
        end
      end
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // weight store
  always_ff @(posedge clk) begin
    if (accept && opc == OP_LOAD_W1 && feed.index < 8'(W1_COUNT))
      w1_mem[ADDR_W'(feed.index)] <= feed.value;
    w1_rdata <= w1_mem[w_addr];
  end

  // gradient store; entries not yet written since clear read as zero
  assign g1_we    = (state == ST_G_WR);
  assign g1_wdata = sat_acc(g1_rvalid ? g1_rdata : 48'sd0, prod_q16[49:0]);

  always_ff @(posedge clk) begin
    if (g1_we) g1_mem[w_addr] <= g1_wdata;
    g1_rdata  <= g1_mem[g1_raddr];
    g1_rvalid <= g1_valid[g1_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && opc == OP_CLEAR)) g1_valid <= '0;
    else if (g1_we)                         g1_valid[w_addr] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (accept && opc == OP_FEATURE && feed.index < 8'(INPUT_COUNT))
      xf[KW'(feed.index)] <= feed.value;
  end

  // sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      kcnt <= '0;
      jcnt <= '0;
    end else begin
      if (state == ST_FWD_ACC || state == ST_G_WR) kcnt <= k_last ? '0 : kcnt + 1'b1;
      if (shift)                                   jcnt <= j_last ? '0 : jcnt + 1'b1;
    end
  end

  // row datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          y      <= feed.value;
          rd_idx <= feed.index;
          acc    <= '0;
        end
      end
      ST_FWD_ACC, ST_OUT_ACC: acc <= acc + ACC_W'(prod_q16);
      ST_FWD_SIG: acc <= '0;
      ST_PRED: begin
        p   <= sig_w;
        err <= 34'({17'b0, sig_w}) - 34'(y);
      end
      ST_D3: delta <= prod_q16[33:0];
      ST_B2: g2n   <= sat_acc(head.g2, prod_q16[49:0]);
      ST_B3: tt    <= prod_q16[47:0];
      ST_B4: hp    <= prod_q16[15:0];
      ST_B5: lowp  <= prod[38:0];
      ST_B6: hd    <= sat32(full >>> 16);
      default: ;
    endcase
  end

  // metrics
  always_ff @(posedge clk) begin
    if (rst || (accept && opc == OP_CLEAR)) begin
      se_sum    <= '0;
      pct_sum   <= '0;
      pct_max   <= '0;
      rows_done <= '0;
    end else begin
      if (state == ST_D4) se_sum <= sat_acc(se_sum, prod_q16[49:0]);
      if (state == ST_PCT) begin
        pct_sum <= sat_acc(pct_sum, 50'(pct));
        if (32'(pct) > pct_max) pct_max <= 32'(pct);
      end
      if (state == ST_DONE && out_free && rows_done != 32'hFFFF_FFFF)
        rows_done <= rows_done + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if ((state == ST_DONE || state == ST_READ) && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      result.read_value  <= 48'({31'b0, p});
      result.result_kind <= 1'b0;
    end else if (state == ST_READ && out_free) begin
      result.result_kind <= 1'b1;
      if (rd_idx < 8'(W1_COUNT))             result.read_value <= g1_rvalid ? g1_rdata : '0;
      else if (rd_idx < 8'(RD_SE))           result.read_value <= cell_q[rd_off[JW-1:0]].g2;
      else if (rd_idx == 8'(RD_SE))          result.read_value <= se_sum;
      else if (rd_idx == 8'(RD_PSUM))        result.read_value <= pct_sum;
      else if (rd_idx == 8'(RD_PMAX))        result.read_value <= 48'({16'b0, pct_max});
      else if (rd_idx == 8'(RD_ROWS))        result.read_value <= 48'({16'b0, rows_done});
      else                                   result.read_value <= '0;
    end
  end

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == ST_DIV)
    else $error("divider busy outside its wait state");

  a_chain_home: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> jcnt == '0 && kcnt == '0)
    else $error("hidden chain not at home position when idle");

  a_rows_mono: assert property (@(posedge clk) disable iff (rst)
    !(accept && opc == OP_CLEAR) |=> rows_done >= $past(rows_done))
    else $error("row count went backwards without clear");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == ST_DONE || $past(state) == ST_READ)
    else $error("result raised outside done or read");

endmodule

### verif/tb_mlp_gradient_accumulator_unit.sv
// Testbench for the gradient accumulator: scoreboard against an in-bench row predictor.
`timescale 1ns / 1ps

module tb_mlp_gradient_accumulator_unit;
  import mga_pkg::*;

  localparam int  IDLE_PCT    = 29;
  localparam int  CYCLE_LIMIT = 2_000_000;
  localparam longint LIM48    = 64'sd1 <<< 47;
  localparam longint Q1       = 65536;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mga_in_if  feed ();
  mga_out_if result ();

  mlp_gradient_accumulator_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint sig_tab [SIG_DEPTH];
  longint w1 [W1_COUNT];
  longint w2 [HIDDEN_COUNT];
  longint feat [INPUT_COUNT];
  longint hid [HIDDEN_COUNT];
  longint g1 [W1_COUNT];
  longint g2 [HIDDEN_COUNT];
  longint sq_err_sum, pct_sum, pct_max, row_count;

  typedef struct {
    logic [47:0] read_value;
    logic        result_kind;
  } answer_t;

  answer_t answers_due [$];
  int      errors;
  int      requests_sent, rows_run, reads_run, answers_seen;
  longint  cycles;
  bit      idle_on;

  function automatic void build_sigmoid();
    longint      num;
    logic [63:0] a, tq, x, g, term, r, den, s;
    for (int i = 0; i < SIG_DEPTH; i++) begin
      num  = 16 * i - 8 * SIG_DEPTH;
      a    = (num < 0) ? 64'(-num) : 64'(num);
      tq   = (a << 32) / SIG_DEPTH;
      x    = tq >> 4;
      g    = 64'd1 << 32;
      term = 64'd1 << 32;
      for (int k = 1; k <= 20; k++) begin
        term = ((term * x) >> 32) / k;
        g    = g + term;
      end
      r = ((64'd1 << 63) / g) << 1;
      if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      for (int k = 0; k < 4; k++) r = (r * r) >> 32;
      den = (64'd1 << 32) + r;
      s   = ((64'd1 << 48) + (den >> 1)) / den;
      sig_tab[i] = (num < 0) ? 65536 - longint'(s) : longint'(s);
    end
  endfunction

  function automatic longint sigmoid_of(longint x);
    longint idx;
    if (x < -(64'sd8 <<< 16)) idx = 0;
    else if (x >= (64'sd8 <<< 16)) idx = SIG_DEPTH - 1;
    else idx = ((x + (64'sd8 <<< 16)) * SIG_DEPTH) >>> 20;
    if (idx > SIG_DEPTH - 1) idx = SIG_DEPTH - 1;
    if (idx < 0) idx = 0;
    return sig_tab[idx];
  endfunction

  function automatic longint clamp(longint v, longint lim);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void clear_sums();
    foreach (g1[i]) g1[i] = 0;
    foreach (g2[i]) g2[i] = 0;
    sq_err_sum = 0;
    pct_sum    = 0;
    pct_max    = 0;
    row_count  = 0;
  endfunction

  function automatic longint train_row(longint y);
    longint acc, raw, p, err, delta, pct, h, hd;
    logic [63:0] ae, ay, q;
    for (int j = 0; j < HIDDEN_COUNT; j++) begin
      acc = 0;
      for (int k = 0; k < INPUT_COUNT; k++)
        acc += (feat[k] * w1[k*HIDDEN_COUNT+j]) >>> 16;
      hid[j] = sigmoid_of(acc);
    end
    raw = 0;
    for (int j = 0; j < HIDDEN_COUNT; j++) raw += (hid[j] * w2[j]) >>> 16;
    p     = sigmoid_of(raw);
    err   = p - y;
    delta = (((err * p) >>> 16) * (Q1 - p)) >>> 16;
    sq_err_sum = clamp(sq_err_sum + ((err * err) >>> 16), LIM48);
    if (y == 0) begin
      pct = 0;
    end else begin
      ae  = (err < 0) ? 64'(-err) : 64'(err);
      ay  = (y < 0) ? 64'(-y) : 64'(y);
      q   = ((ae * 100) << 16) / ay;
      pct = (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
    end
    pct_sum = clamp(pct_sum + pct, LIM48);
    if (pct > pct_max) pct_max = pct;
    for (int j = 0; j < HIDDEN_COUNT; j++) begin
      h  = hid[j];
      hd = (((delta * w2[j]) >>> 16) * ((h * (Q1 - h)) >>> 16)) >>> 16;
      hd = clamp(hd, 64'sd1 <<< 31);
      g2[j] = clamp(g2[j] + ((h * delta) >>> 16), LIM48);
      for (int k = 0; k < INPUT_COUNT; k++)
        g1[k*HIDDEN_COUNT+j] = clamp(g1[k*HIDDEN_COUNT+j] + ((feat[k] * hd) >>> 16), LIM48);
    end
    if (row_count != 64'hFFFF_FFFF) row_count++;
    return p;
  endfunction

  function automatic longint read_sum(int idx);
    if (idx < W1_COUNT) return g1[idx];
    if (idx < RD_SE) return g2[idx - W1_COUNT];
    case (idx)
      RD_SE:   return sq_err_sum;
      RD_PSUM: return pct_sum;
      RD_PMAX: return pct_max;
      RD_ROWS: return row_count;
      default: return 0;
    endcase
  endfunction

  // work out what one accepted request should produce
  function automatic void apply_request(logic [2:0] op, logic [7:0] idx, logic signed [31:0] val);
    answer_t a;
    case (op)
      OP_LOAD_W1: if (idx < W1_COUNT) w1[idx] = val;
      OP_LOAD_W2: if (idx < HIDDEN_COUNT) w2[idx] = val;
      OP_FEATURE: if (idx < INPUT_COUNT) feat[idx] = val;
      OP_TARGET: begin
        a.read_value  = 48'(train_row(longint'(val)));
        a.result_kind = 1'b0;
        answers_due.push_back(a);
        rows_run++;
      end
      OP_READ: begin
        a.read_value  = 48'(read_sum(idx));
        a.result_kind = 1'b1;
        answers_due.push_back(a);
        reads_run++;
      end
      OP_CLEAR: clear_sums();
      default: ;
    endcase
  endfunction

  // send one request; valid stays high into the next call unless it idles
  task automatic send(logic [2:0] op, logic [7:0] idx, logic signed [31:0] val);
    bit first;
    first = 1'b1;
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      if (first) feed.valid <= 1'b0;
      first = 1'b0;
      @(posedge clk);
    end
    feed.valid  <= 1'b1;
    feed.opcode <= op;
    feed.index  <= idx;
    feed.value  <= val;
    @(negedge clk);
    while (!feed.ready) @(negedge clk);
    @(posedge clk);
    apply_request(op, idx, val);
    requests_sent++;
  endtask

  function automatic logic signed [31:0] small_val(int span);
    return $signed(32'($urandom_range(2 * span))) - span;
  endfunction

  task automatic load_network(int span);
    for (int i = 0; i < W1_COUNT; i++) send(OP_LOAD_W1, 8'(i), small_val(span));
    for (int i = 0; i < HIDDEN_COUNT; i++) send(OP_LOAD_W2, 8'(i), small_val(span));
    for (int i = 0; i < INPUT_COUNT; i++) send(OP_FEATURE, 8'(i), small_val(4 * 65536));
  endtask

  // sample the input-layer gradients, then every output-layer gradient and metric, then two unmapped indexes
  task automatic read_everything();
    for (int i = 0; i < W1_COUNT; i += 7) send(OP_READ, 8'(i), $urandom);
    for (int i = W1_COUNT; i <= RD_ROWS; i++) send(OP_READ, 8'(i), $urandom);
    send(OP_READ, 8'(RD_ROWS + 1), 32'sh0);
    send(OP_READ, 8'hFF, 32'shFFFF_FFFF);
  endtask

  task automatic test_setup();
    load_network(2 * 65536);
  endtask

  task automatic test_directed_rows();
    send(OP_TARGET, 8'd0, 32'sh0);               // zero target
    send(OP_TARGET, 8'd0, 32'sh7FFF_FFFF);
    send(OP_TARGET, 8'd0, 32'sh8000_0000);
    send(OP_TARGET, 8'd0, 32'sh0000_8000);
    send(OP_TARGET, 8'd0, -32'sd1);
    // drive the hidden and output sigmoids hard into both ends of the table
    send(OP_LOAD_W2, 8'd0, 32'sh7FFF_FFFF);
    send(OP_FEATURE, 8'd0, 32'sh7FFF_FFFF);
    send(OP_LOAD_W1, 8'd0, 32'sh7FFF_FFFF);
    send(OP_TARGET, 8'd0, 32'sh0001_0000);
    send(OP_LOAD_W1, 8'd0, 32'sh8000_0000);
    send(OP_LOAD_W2, 8'd0, 32'sh8000_0000);
    send(OP_TARGET, 8'd0, 32'sh0000_0001);
    read_everything();
  endtask

  task automatic test_ignored();
    send(OP_LOAD_W1, 8'(W1_COUNT), 32'sh1234_5678);
    send(OP_LOAD_W1, 8'hFF, 32'sh7FFF_FFFF);
    send(OP_LOAD_W2, 8'(HIDDEN_COUNT), 32'sh8000_0000);
    send(OP_FEATURE, 8'(INPUT_COUNT), 32'sh5555_AAAA);
    send(3'd6, 8'hAA, 32'shAAAA_5555);
    send(3'd7, 8'h55, 32'shFFFF_FFFF);
    send(OP_TARGET, 8'hFF, 32'sh0002_0000);
  endtask

  task automatic test_clear();
    send(OP_CLEAR, 8'd0, 32'sh0);
    read_everything();
    send(OP_TARGET, 8'd0, 32'sh0000_C000);
  endtask

  task automatic test_random(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      idle_on = !(n >= count / 3 && n < count / 2);
      r = $urandom_range(99);
      if (r < 10)
        send(OP_LOAD_W1, 8'($urandom_range(r < 2 ? 255 : W1_COUNT - 1)),
             r < 3 ? $signed($urandom) : small_val(3 * 65536));
      else if (r < 15)
        send(OP_LOAD_W2, 8'($urandom_range(r < 11 ? 255 : HIDDEN_COUNT - 1)),
             r < 12 ? $signed($urandom) : small_val(3 * 65536));
      else if (r < 38)
        send(OP_FEATURE, 8'($urandom_range(r < 17 ? 255 : INPUT_COUNT - 1)),
             r < 20 ? $signed($urandom) : small_val(6 * 65536));
      else if (r < 53)
        send(OP_TARGET, 8'($urandom),
             r < 41 ? $signed($urandom) : (r < 43 ? 32'sh0 : small_val(65536)));
      else if (r < 95)
        send(OP_READ, 8'(r < 90 ? $urandom_range(RD_ROWS) : $urandom), $signed($urandom));
      else if (r < 97)
        send(OP_CLEAR, 8'($urandom), $signed($urandom));
      else
        send(3'($urandom_range(7, 6)), 8'($urandom), $signed($urandom));
    end
    idle_on = 1'b1;
  endtask

  // result side: random stall, compare against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      if (result.valid && result.ready) begin
        answers_seen++;
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result value=%h kind=%b", $time,
                   result.read_value, result.result_kind);
          errors++;
        end else begin
          if (result.read_value !== answers_due[0].read_value) begin
            $display("%0t: read_value expected %h actual %h", $time,
                     answers_due[0].read_value, result.read_value);
            errors++;
          end
          if (result.result_kind !== answers_due[0].result_kind) begin
            $display("%0t: result_kind expected %b actual %b", $time,
                     answers_due[0].result_kind, result.result_kind);
            errors++;
          end
          void'(answers_due.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, answers_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int wait_cycles;
    errors = 0; requests_sent = 0; rows_run = 0; reads_run = 0; answers_seen = 0;
    cycles = 0;
    idle_on = 1'b1;
    feed.valid  = 1'b0;
    feed.opcode = '0;
    feed.index  = '0;
    feed.value  = '0;
    build_sigmoid();
    foreach (w1[i]) w1[i] = 0;
    foreach (w2[i]) w2[i] = 0;
    foreach (feat[i]) feat[i] = 0;
    foreach (hid[i]) hid[i] = 0;
    clear_sums();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_setup();
    test_directed_rows();
    test_ignored();
    test_clear();
    test_random(100);
    read_everything();

    feed.valid <= 1'b0;
    wait_cycles = 0;
    while (answers_due.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (answers_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, answers_due.size());
      errors++;
    end
    $display("Covered %0d requests: %0d training rows, %0d accumulator reads, %0d results checked.",
             requests_sent, rows_run, reads_run, answers_seen);
    $display("Loads, features, clears, ignored opcodes and out-of-range indexes included.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
